FILE: rtl/spw_pkg.sv
package spw_pkg;

	// channel count and derived index width
	localparam int SERVO_COUNT = 16;
	localparam int SERVO_W     = 4;
	localparam int IDX_W       = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;

	// item field widths
	localparam int ANGLE_W = 8;
	localparam int LIMIT_W = 16;
	localparam int PULSE_W = 12;
	localparam int LAST_W  = PULSE_W + 1;
	localparam int BYTE_W  = 8;

	// mapping constants
	localparam int FULL_ANGLE  = 180;
	localparam int ROUND_UP    = FULL_ANGLE - 1;
	localparam int PULSE_MAX   = 4095;
	localparam int PULSE_NEVER = 4096;
	localparam logic [BYTE_W-1:0] FIRST_REG = 8'h06;

	// angle * span + rounding term fits in 20 bits (180 * 4095 + 179)
	localparam int PROD_W = 20;

	// floor(n / 180) as (n * RECIP) >> RECIP_SHIFT, exact for n < 2**PROD_W
	localparam int RECIP_SHIFT = 28;
	localparam int RECIP       = ((2 ** RECIP_SHIFT) + FULL_ANGLE - 1) / FULL_ANGLE;
	localparam int RECIP_W     = 21;
	localparam int QUOT_W      = PROD_W + RECIP_W;

	// job queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	typedef logic [IDX_W-1:0] chan_t;

	typedef struct packed {
		chan_t              ch;
		logic [PULSE_W-1:0] pulse;
	} spw_job_t;

	typedef enum logic [1:0] {
		FE_IDLE,
		FE_MUL,
		FE_DIV,
		FE_CMP
	} fe_state_t;

	// byte index of a write beat within the channel's register group
	typedef enum logic [1:0] {
		BEAT_ON_LO,
		BEAT_ON_HI,
		BEAT_OFF_LO,
		BEAT_OFF_HI
	} beat_t;

endpackage

FILE: rtl/spw_ifs.sv
interface spw_req_if;
	logic                           valid;
	logic                           ready;
	logic                           cmd;
	logic [spw_pkg::SERVO_W-1:0]    servo;
	logic [spw_pkg::ANGLE_W-1:0]    angle;
	logic [spw_pkg::LIMIT_W-1:0]    low_limit;
	logic [spw_pkg::LIMIT_W-1:0]    high_limit;

	modport source (output valid, cmd, servo, angle, low_limit, high_limit, input ready);
	modport sink (input valid, cmd, servo, angle, low_limit, high_limit, output ready);
endinterface

interface spw_wr_if;
	logic                           valid;
	logic                           ready;
	logic [spw_pkg::BYTE_W-1:0]     reg_addr;
	logic [spw_pkg::BYTE_W-1:0]     reg_data;
	logic [spw_pkg::PULSE_W-1:0]    pulse_count;
	logic                           last_write;

	modport source (output valid, reg_addr, reg_data, pulse_count, last_write, input ready);
	modport sink (input valid, reg_addr, reg_data, pulse_count, last_write, output ready);
endinterface

FILE: rtl/spw_front.sv
module spw_front (
	input  logic             clk,
	input  logic             arst_n,
	spw_req_if.sink          req,
	output logic             push,
	output spw_pkg::spw_job_t push_job,
	input  logic             full
);

	spw_pkg::fe_state_t state_q, state_d;

	logic [spw_pkg::PULSE_W-1:0] low_limits_q  [spw_pkg::SERVO_COUNT];
	logic [spw_pkg::PULSE_W-1:0] high_limits_q [spw_pkg::SERVO_COUNT];
	logic [spw_pkg::LAST_W-1:0]  last_pulse_q  [spw_pkg::SERVO_COUNT];

	spw_pkg::chan_t              ch_q;
	logic [spw_pkg::ANGLE_W-1:0] angle_q;
	logic [spw_pkg::PULSE_W-1:0] low_q;
	logic [spw_pkg::PULSE_W-1:0] mag_q;
	logic                        down_q;
	logic [spw_pkg::PROD_W-1:0]  num_q;
	logic [spw_pkg::PULSE_W-1:0] pulse_q;

	logic                        accept;
	logic                        in_range;
	spw_pkg::chan_t              sel;
	logic [spw_pkg::PULSE_W-1:0] lo_cur, hi_cur;
	logic [spw_pkg::PULSE_W-1:0] lo_clamp, hi_clamp;
	logic [spw_pkg::ANGLE_W-1:0] angle_sat;
	logic [spw_pkg::PROD_W-1:0]  num_d;
	logic [spw_pkg::QUOT_W-1:0]  quot_full;
	logic [spw_pkg::PULSE_W-1:0] quot;
	logic [spw_pkg::PULSE_W-1:0] pulse_d;
	logic                        changed;
	logic                        store_pulse;

	assign req.ready = (state_q == spw_pkg::FE_IDLE);
	assign accept    = req.valid && req.ready;
	assign in_range  = ({1'b0, req.servo} < (spw_pkg::SERVO_W + 1)'(spw_pkg::SERVO_COUNT));
	assign sel       = req.servo[spw_pkg::IDX_W-1:0];
	assign lo_cur    = low_limits_q[sel];
	assign hi_cur    = high_limits_q[sel];

	assign lo_clamp  = (req.low_limit > spw_pkg::LIMIT_W'(spw_pkg::PULSE_MAX)) ?
		spw_pkg::PULSE_W'(spw_pkg::PULSE_MAX) : req.low_limit[spw_pkg::PULSE_W-1:0];
	assign hi_clamp  = (req.high_limit > spw_pkg::LIMIT_W'(spw_pkg::PULSE_MAX)) ?
		spw_pkg::PULSE_W'(spw_pkg::PULSE_MAX) : req.high_limit[spw_pkg::PULSE_W-1:0];
	assign angle_sat = (req.angle > spw_pkg::ANGLE_W'(spw_pkg::FULL_ANGLE)) ?
		spw_pkg::ANGLE_W'(spw_pkg::FULL_ANGLE) : req.angle;

	// downward mapping rounds the magnitude up, so floor of the signed quotient
	assign num_d = (spw_pkg::PROD_W'(angle_q) * spw_pkg::PROD_W'(mag_q)) +
		(down_q ? spw_pkg::PROD_W'(spw_pkg::ROUND_UP) : '0);

	assign quot_full = spw_pkg::QUOT_W'(num_q) * spw_pkg::QUOT_W'(spw_pkg::RECIP);
	assign quot      = quot_full[spw_pkg::RECIP_SHIFT +: spw_pkg::PULSE_W];
	assign pulse_d   = down_q ? (low_q - quot) : (low_q + quot);

	assign changed   = (last_pulse_q[ch_q] != {1'b0, pulse_q});
	assign push_job  = '{ch: ch_q, pulse: pulse_q};

	always_comb begin
		state_d     = state_q;
		push        = 1'b0;
		store_pulse = 1'b0;
		unique case (state_q)
			spw_pkg::FE_IDLE: begin
				if (accept && in_range && req.cmd) begin
					state_d = spw_pkg::FE_MUL;
				end
			end
			spw_pkg::FE_MUL: begin
				state_d = spw_pkg::FE_DIV;
			end
			spw_pkg::FE_DIV: begin
				state_d = spw_pkg::FE_CMP;
			end
			spw_pkg::FE_CMP: begin
				if (!changed) begin
					state_d = spw_pkg::FE_IDLE;
				end else if (!full) begin
					push        = 1'b1;
					store_pulse = 1'b1;
					state_d     = spw_pkg::FE_IDLE;
				end
			end
			default: begin
				state_d = spw_pkg::FE_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spw_pkg::FE_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// per-channel limits and last written pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < spw_pkg::SERVO_COUNT; i++) begin
				low_limits_q[i]  <= '0;
				high_limits_q[i] <= spw_pkg::PULSE_W'(spw_pkg::PULSE_MAX);
				last_pulse_q[i]  <= spw_pkg::LAST_W'(spw_pkg::PULSE_NEVER);
			end
		end else begin
			if (accept && in_range && !req.cmd) begin
				low_limits_q[sel]  <= lo_clamp;
				high_limits_q[sel] <= hi_clamp;
			end
			if (store_pulse) begin
				last_pulse_q[ch_q] <= {1'b0, pulse_q};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q    <= sel;
			angle_q <= angle_sat;
			low_q   <= lo_cur;
			down_q  <= (hi_cur < lo_cur);
			mag_q   <= (hi_cur < lo_cur) ? (lo_cur - hi_cur) : (hi_cur - lo_cur);
		end
		if (state_q == spw_pkg::FE_MUL) begin
			num_q <= num_d;
		end
		if (state_q == spw_pkg::FE_DIV) begin
			pulse_q <= pulse_d;
		end
	end

	// a job only leaves the compare step, with room in the queue and a new pulse
	a_push_from_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (state_q == spw_pkg::FE_CMP) && !full && changed)
		else $error("job pushed outside compare step");

endmodule

FILE: rtl/spw_queue.sv
module spw_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  spw_pkg::spw_job_t push_job,
	output logic              full,
	input  logic              pop,
	output spw_pkg::spw_job_t pop_job,
	output logic              empty
);

	spw_pkg::spw_job_t             slots_q [spw_pkg::QUEUE_DEPTH];
	logic [spw_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [spw_pkg::QCNT_W-1:0]    count_q;

	assign full    = (count_q == spw_pkg::QCNT_W'(spw_pkg::QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign pop_job = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

endmodule

FILE: rtl/spw_back.sv
module spw_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	input  spw_pkg::spw_job_t pop_job,
	output logic              pop,
	spw_wr_if.source          wr
);

	logic              busy_q;
	spw_pkg::spw_job_t job_q;
	spw_pkg::beat_t    beat_q;

	logic fire;
	logic done;

	assign fire = wr.valid && wr.ready;
	assign done = fire && (beat_q == spw_pkg::BEAT_OFF_HI);
	assign pop  = !empty && (!busy_q || done);

	assign wr.valid       = busy_q;
	assign wr.reg_addr    = spw_pkg::FIRST_REG + spw_pkg::BYTE_W'({job_q.ch, beat_q});
	assign wr.pulse_count = job_q.pulse;
	assign wr.last_write  = (beat_q == spw_pkg::BEAT_OFF_HI);

	always_comb begin
		unique case (beat_q)
			spw_pkg::BEAT_ON_LO:  wr.reg_data = '0;
			spw_pkg::BEAT_ON_HI:  wr.reg_data = '0;
			spw_pkg::BEAT_OFF_LO: wr.reg_data = job_q.pulse[spw_pkg::BYTE_W-1:0];
			spw_pkg::BEAT_OFF_HI: wr.reg_data =
				spw_pkg::BYTE_W'(job_q.pulse[spw_pkg::PULSE_W-1:spw_pkg::BYTE_W]);
			default:              wr.reg_data = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			beat_q <= spw_pkg::BEAT_ON_LO;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				beat_q <= spw_pkg::BEAT_ON_LO;
			end else if (done) begin
				busy_q <= 1'b0;
			end else if (fire) begin
				beat_q <= spw_pkg::beat_t'(beat_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= pop_job;
		end
	end

	// the final beat carries the high byte of the pulse it reports
	a_last_high_byte: assert property (@(posedge clk) disable iff (!arst_n)
		wr.valid && wr.last_write |->
			wr.reg_data == spw_pkg::BYTE_W'(wr.pulse_count[spw_pkg::PULSE_W-1:spw_pkg::BYTE_W]))
		else $error("last beat data does not match pulse high byte");

endmodule

FILE: rtl/servo_angle_to_pwm_register_writer_unit.sv
// servo angle to pwm register writer: each of 16 servo channels keeps a 12-bit low and high
// pulse limit (reset 0 and 4095) and the last pulse it wrote. a beat on req with cmd = 0 stores
// the channel's limits, each clamped to 4095, and gives no output. a beat with cmd = 1 saturates
// angle to 180 and computes pulse = low + floor(angle * (high - low) / 180) exactly, also when
// high is below low; when that differs from the channel's last pulse, four register write beats
// leave on wr: addresses 6 + 4*servo + 0..3 carrying 0, 0, pulse low byte, pulse high byte, with
// pulse_count on every beat and last_write on the fourth. an unchanged pulse or a servo number
// beyond the channel count gives nothing. flow: a limits beat is stored when it is accepted; a
// position beat holds the input off through accept, multiply, reciprocal divide, compare and
// store, and compare waits while the queue is full. jobs wait in a two-entry queue, and the write
// side drains one beat per cycle when wr is ready. no clearing pass after reset
module servo_angle_to_pwm_register_writer_unit (
	input  logic     clk,
	input  logic     arst_n,
	spw_req_if.sink  req,
	spw_wr_if.source wr
);

	// jobs handed from the compute front to the write-out back
	logic              push;
	logic              full;
	logic              pop;
	logic              empty;
	spw_pkg::spw_job_t push_job;
	spw_pkg::spw_job_t pop_job;

	// limits table, angle mapping and change detect
	spw_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.push     (push),
		.push_job (push_job),
		.full     (full)
	);

	// short queue so the front keeps working while writes are stalled
	spw_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.pop_job  (pop_job),
		.empty    (empty)
	);

	// four register write beats per job
	spw_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.empty   (empty),
		.pop_job (pop_job),
		.pop     (pop),
		.wr      (wr)
	);

endmodule
